/* hw/rtl/pvmt_pkg.sv */
// Shared types, codes and reset constants of the priority velocity mux.
package pvmt_pkg;

  localparam int unsigned NumAxes    = 6;
  localparam int unsigned VelW       = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned DeadbandW  = 15;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 4;

  // Axis positions inside a velocity vector.
  localparam int unsigned AxisLinX = 0;
  localparam int unsigned AxisLinY = 1;
  localparam int unsigned AxisAngZ = 5;

  localparam logic [DeadbandW-1:0] DeadbandReset = DeadbandW'(205);
  localparam logic [TimeoutW-1:0]  TimeoutReset  = TimeoutW'(500);

  typedef enum logic [1:0] {
    ActManual = 2'd0,
    ActAuto   = 2'd1,
    ActTick   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SrcNone   = 2'd0,
    SrcManual = 2'd1,
    SrcAuto   = 2'd2
  } source_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgDeadband = 8'd0,
    CfgTimeout  = 8'd1
  } cfg_index_e;

  typedef logic signed [VelW-1:0] vel_t;
  typedef vel_t [NumAxes-1:0]     vel_vec_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    action_e            action;
    logic [TimeW-1:0]   time_ms;
    vel_vec_t           vel;
    logic               active;
  } entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

/* hw/rtl/pvmt_front.sv */
// Front end: accepts input transactions, decodes the action and flags manual activity.
module pvmt_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [127:0]                    s_axis_tdata,  // time_ms, lin_x, lin_y, lin_z,
                                                         // ang_x, ang_y, ang_z
  input  logic [1:0]                      s_axis_tuser,  // action
  input  logic [pvmt_pkg::DeadbandW-1:0]  deadband_i,
  input  pvmt_pkg::queue_status_t         q_status_i,
  output logic                            push_o,
  output pvmt_pkg::entry_t                entry_o
);
  import pvmt_pkg::*;

  vel_vec_t vel;
  logic     known_action;

  // Strictly greater than the deadband; the most negative value always counts.
  function automatic logic exceeds(vel_t v, logic [DeadbandW-1:0] db);
    logic signed [VelW:0] ext;
    logic signed [VelW:0] mag;
    ext = {v[VelW-1], v};
    mag = ext[VelW] ? -ext : ext;
    return mag > $signed({2'b00, db});
  endfunction

  assign vel = s_axis_tdata[TimeW +: NumAxes*VelW];

  always_comb begin
    case (s_axis_tuser)
      ActManual, ActAuto, ActTick: known_action = 1'b1;
      default:                     known_action = 1'b0;
    endcase
  end

  assign s_axis_tready = !q_status_i.full;
  // Drop the unused action code after the handshake.
  assign push_o        = s_axis_tvalid && !q_status_i.full && known_action;

  assign entry_o.action  = action_e'(s_axis_tuser);
  assign entry_o.time_ms = s_axis_tdata[TimeW-1:0];
  assign entry_o.vel     = vel;
  assign entry_o.active  = exceeds(vel[AxisLinX], deadband_i) ||
                           exceeds(vel[AxisLinY], deadband_i) ||
                           exceeds(vel[AxisAngZ], deadband_i);

endmodule

/* hw/rtl/pvmt_queue.sv */
// Short register queue between the front end and the back end.
module pvmt_queue #(
  parameter int unsigned Depth = pvmt_pkg::QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  pvmt_pkg::entry_t        entry_i,
  input  logic                    pop_i,
  output pvmt_pkg::queue_status_t status_o,
  output pvmt_pkg::entry_t        head_o
);
  import pvmt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign do_push = push_i && (count_q != FullCnt);
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.valid = (count_q != '0);
  assign head_o         = store_q[rd_ptr_q];

endmodule

/* hw/rtl/pvmt_back.sv */
// Back end: applies commands to the source state and turns ticks into result transactions.
module pvmt_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [pvmt_pkg::TimeoutW-1:0]  timeout_ms_i,
  input  pvmt_pkg::queue_status_t        q_status_i,
  input  pvmt_pkg::entry_t               head_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // out_lin_x, out_lin_y, out_lin_z,
                                                        // out_ang_x, out_ang_y, out_ang_z
  output logic [2:0]                     m_axis_tuser   // source, source_changed
);
  import pvmt_pkg::*;

  vel_vec_t         manual_vel_q, auto_vel_q;
  logic             manual_seen_q, auto_seen_q;
  logic             manual_mode_q, manual_mode_d;
  logic [TimeW-1:0] last_act_q;
  source_e          cur_src_q;

  logic             out_valid_q;
  vel_vec_t         out_vel_q;
  source_e          out_src_q;
  logic             out_changed_q;

  logic [TimeW-1:0] elapsed;
  logic             mode_kept;
  source_e          src;
  logic             changed, emit;
  logic             out_free;
  logic             is_tick, is_manual, is_auto;
  vel_vec_t         sel_vel;

  assign is_tick   = (head_i.action == ActTick);
  assign is_manual = (head_i.action == ActManual);
  assign is_auto   = (head_i.action == ActAuto);

  // A tick needs room in the output register; commands never wait.
  assign out_free = !out_valid_q || m_axis_tready;
  assign pop_o    = q_status_i.valid && (!is_tick || out_free);

  assign elapsed   = head_i.time_ms - last_act_q;
  assign mode_kept = manual_mode_q && !(elapsed > {{(TimeW-TimeoutW){1'b0}}, timeout_ms_i});

  always_comb begin
    if (mode_kept && manual_seen_q) begin
      src = SrcManual;
    end else if (auto_seen_q) begin
      src = SrcAuto;
    end else begin
      src = SrcNone;
    end
    case (src)
      SrcManual: sel_vel = manual_vel_q;
      SrcAuto:   sel_vel = auto_vel_q;
      default:   sel_vel = '0;
    endcase
  end

  assign changed = (src != cur_src_q);
  assign emit    = changed || (src != SrcNone);

  always_comb begin
    manual_mode_d = manual_mode_q;
    if (pop_o && is_tick) begin
      manual_mode_d = mode_kept;
    end else if (pop_o && is_manual && head_i.active) begin
      manual_mode_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_seen_q <= 1'b0;
      auto_seen_q   <= 1'b0;
      manual_mode_q <= 1'b0;
      last_act_q    <= '0;
      cur_src_q     <= SrcNone;
      out_valid_q   <= 1'b0;
    end else begin
      manual_mode_q <= manual_mode_d;
      if (pop_o && is_manual) begin
        manual_seen_q <= 1'b1;
        if (head_i.active) begin
          last_act_q <= head_i.time_ms;
        end
      end
      if (pop_o && is_auto) begin
        auto_seen_q <= 1'b1;
      end
      if (pop_o && is_tick && emit) begin
        cur_src_q   <= src;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_manual) begin
      manual_vel_q <= head_i.vel;
    end
    if (pop_o && is_auto) begin
      auto_vel_q <= head_i.vel;
    end
    if (pop_o && is_tick && emit) begin
      out_vel_q     <= sel_vel;
      out_src_q     <= src;
      out_changed_q <= changed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_vel_q;
  assign m_axis_tuser  = {out_changed_q, out_src_q};

endmodule

/* hw/rtl/priority_velocity_mux_timeout_core.sv */
// Top level of the two-source velocity command mux with manual timeout.
//
//  Channel  Dir  Handshake                   Payload
//  s_axis   in   s_axis_tvalid/tready        tdata: time_ms, lin_x..ang_z; tuser: action
//  m_axis   out  m_axis_tvalid/tready        tdata: out_lin_x..out_ang_z;
//                                            tuser: source, source_changed
//  cfg      in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One s_axis transaction per cycle while the queue has room; the back end drains
// one entry per cycle, while a tick waits for room in the output register. A tick
// enters the queue at its accepting edge; its result, if any, is registered when popped.
// Reset clears the queue and the mode and source state, and restores the default deadband and timeout.
// A stalled m_axis holds a tick at the queue head; commands behind it wait,
// and s_axis stalls once the queue is full.
module priority_velocity_mux_timeout_core #(
  parameter int unsigned QueueDepth = pvmt_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [127:0]                   s_axis_tdata,  // time_ms, lin_x, lin_y, lin_z,
                                                        // ang_x, ang_y, ang_z
  input  logic [1:0]                     s_axis_tuser,  // action
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // out_lin_x, out_lin_y, out_lin_z,
                                                        // out_ang_x, out_ang_y, out_ang_z
  output logic [2:0]                     m_axis_tuser,  // source, source_changed
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pvmt_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [pvmt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pvmt_pkg::*;

  logic [DeadbandW-1:0] deadband_q;
  logic [TimeoutW-1:0]  timeout_q;

  queue_status_t q_status;
  logic          push, pop;
  entry_t        push_entry, head_entry;

  // Configuration registers accept a write every cycle; unknown indexes drop.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DeadbandReset;
      timeout_q  <= TimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgDeadband: deadband_q <= cfg_data_i[DeadbandW-1:0];
        CfgTimeout:  timeout_q  <= cfg_data_i[TimeoutW-1:0];
        default:     ;
      endcase
    end
  end

  // Decode and classify each input transaction.
  pvmt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .deadband_i    (deadband_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  // Decouple the input side from output back-pressure.
  pvmt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .status_o (q_status),
    .head_o   (head_entry)
  );

  // Apply commands, arbitrate on ticks and register the result.
  pvmt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timeout_ms_i  (timeout_q),
    .q_status_i    (q_status),
    .head_i        (head_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* sim/pvmt_mux_checker.sv */
`timescale 1ns / 100ps
// Checker for the velocity mux: predicts each published command and compares.
module pvmt_mux_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [127:0]                   in_data_i,    // time_ms, lin_x, lin_y, lin_z,
                                                       // ang_x, ang_y, ang_z
  input  logic [1:0]                     in_user_i,    // action
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [95:0]                    out_data_i,   // out_lin_x .. out_ang_z
  input  logic [2:0]                     out_user_i,   // source, source_changed
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pvmt_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [pvmt_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o
);
  import pvmt_pkg::*;

  typedef struct packed {
    vel_vec_t vel;
    source_e  src;
    logic     changed;
  } publish_t;

  publish_t         publish_q[$];
  vel_vec_t         manual_vel;
  vel_vec_t         auto_vel;
  logic             manual_seen;
  logic             auto_seen;
  logic             manual_mode;
  logic [TimeW-1:0] last_activity;
  source_e          held_src;
  logic [DeadbandW-1:0] deadband;
  logic [TimeoutW-1:0]  timeout;

  string axis_name [NumAxes] = '{"out_lin_x", "out_lin_y", "out_lin_z",
                                 "out_ang_x", "out_ang_y", "out_ang_z"};

  // The most negative value has magnitude 32768 and beats any deadband.
  function automatic bit exceeds(input vel_t v, input logic [DeadbandW-1:0] limit);
    int mag;
    mag = int'(v);
    if (mag < 0) mag = -mag;
    return mag > int'(limit);
  endfunction

  task automatic route_item(input logic [1:0] act, input logic [TimeW-1:0] now,
                            input vel_vec_t vel);
    logic [TimeW-1:0] elapsed;
    source_e          src;
    publish_t         entry;
    case (act)
      ActManual: begin
        manual_vel  = vel;
        manual_seen = 1'b1;
        if (exceeds(vel[AxisLinX], deadband) || exceeds(vel[AxisLinY], deadband) ||
            exceeds(vel[AxisAngZ], deadband)) begin
          last_activity = now;
          manual_mode   = 1'b1;
        end
      end
      ActAuto: begin
        auto_vel  = vel;
        auto_seen = 1'b1;
      end
      ActTick: begin
        elapsed = now - last_activity;
        if (manual_mode && elapsed > TimeW'(timeout)) manual_mode = 1'b0;
        if (manual_mode && manual_seen) src = SrcManual;
        else if (auto_seen) src = SrcAuto;
        else src = SrcNone;
        // A quiet source that stays quiet publishes nothing.
        if (src != held_src || src != SrcNone) begin
          entry.vel     = (src == SrcManual) ? manual_vel :
                          (src == SrcAuto)   ? auto_vel   : '0;
          entry.src     = src;
          entry.changed = (src != held_src);
          publish_q.push_back(entry);
          held_src = src;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_output();
    publish_t want;
    vel_vec_t got;
    got = out_data_i;
    if (publish_q.size() == 0) begin
      $error("unexpected output transaction: no publish waiting");
      fail_count_o++;
    end else begin
      want = publish_q.pop_front();
      for (int i = 0; i < NumAxes; i++) begin
        if (got[i] !== want.vel[i]) begin
          $error("%s: expected %0d, got %0d", axis_name[i], want.vel[i], got[i]);
          fail_count_o++;
        end
      end
      if (out_user_i[1:0] !== want.src) begin
        $error("source: expected %0d, got %0d", want.src, out_user_i[1:0]);
        fail_count_o++;
      end
      if (out_user_i[2] !== want.changed) begin
        $error("source_changed: expected %0d, got %0d", want.changed, out_user_i[2]);
        fail_count_o++;
      end
      checked_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      publish_q.delete();
      manual_vel    = '0;
      auto_vel      = '0;
      manual_seen   = 1'b0;
      auto_seen     = 1'b0;
      manual_mode   = 1'b0;
      last_activity = '0;
      held_src      = SrcNone;
      deadband      = DeadbandReset;
      timeout       = TimeoutReset;
      fail_count_o  = 0;
      pending_o     = 0;
      checked_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_output();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDeadband: deadband = cfg_data_i[DeadbandW-1:0];
          CfgTimeout:  timeout  = cfg_data_i[TimeoutW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        route_item(in_user_i, in_data_i[TimeW-1:0], vel_vec_t'(in_data_i[127:TimeW]));
      end
      pending_o = publish_q.size();
    end
  end

endmodule

/* sim/priority_velocity_mux_timeout_core_test.sv */
`timescale 1ns / 100ps
// Testbench top for the velocity mux: clock, reset, stimulus, watchdog and verdict.
module priority_velocity_mux_timeout_core_test;
  import pvmt_pkg::*;

  // Action code the block must drop without a trace.
  localparam logic [1:0]  ActUnused     = 2'd3;
  localparam int unsigned HalfPeriod    = 6;
  // Queue stages plus output register, with margin, for commands still in flight.
  localparam int unsigned SettleCycles  = QueueDepth + 8;
  localparam int unsigned IdleLimit     = 3000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned PhaseItems    = 145;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [127:0]         s_axis_tdata;   // time_ms, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
  logic [1:0]           s_axis_tuser;   // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [95:0]          m_axis_tdata;   // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y,
                                        // out_ang_z
  logic [2:0]           m_axis_tuser;   // source, source_changed
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Shared between the stimulus and the receiver process.
  bit          calm;        // no random gaps on either side
  bit          hold_req;    // ask the receiver for one long hold-off
  int unsigned rx_stall;
  int unsigned idle_cycles;

  // Stimulus bookkeeping.
  int unsigned      cur_db;
  int unsigned      cur_to;
  logic [TimeW-1:0] now_ms;
  logic [TimeW-1:0] last_manual_ms;
  int unsigned      n_items;
  int unsigned      n_ticks;
  int unsigned      n_cmds;
  int unsigned      n_ignored;
  int unsigned      n_settings;

  priority_velocity_mux_timeout_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pvmt_mux_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #(HalfPeriod) clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic vel_vec_t mk_vel(input vel_t lx, input vel_t ly, input vel_t lz,
                                      input vel_t ax, input vel_t ay, input vel_t az);
    return {az, ay, ax, lz, ly, lx};
  endfunction

  // Pick a deadband-relevant axis value: around the threshold, extreme or random.
  function automatic vel_t pick_axis();
    int m;
    case ($urandom_range(0, 7))
      0: m = 0;
      1: m = cur_db;
      2: m = cur_db + 1;
      3: m = (cur_db > 0) ? cur_db - 1 : 0;
      4: m = $urandom_range(0, cur_db);
      5: return vel_t'(16'h8000);
      default: return vel_t'($urandom());
    endcase
    if ($urandom_range(0, 1) == 1) m = -m;
    return vel_t'(m);
  endfunction

  // Offer one transaction after a random gap; return at the edge that takes it.
  // Ready is sampled at the falling edge so the handshake never races the DUT.
  task automatic send_item(input logic [1:0] act, input logic [TimeW-1:0] t,
                           input vel_vec_t v);
    int unsigned gap;
    logic        rdy;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, t};
    s_axis_tuser  <= act;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    n_items++;
    if (act == ActTick) n_ticks++;
    else if (act == ActUnused) n_ignored++;
    else n_cmds++;
  endtask

  // Drop valid, wait for every publish to come out, then let queued commands drain.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Hold valid high across back-to-back writes; the caller lowers it.
  task automatic cfg_write(input cfg_index_e idx, input logic [CfgDataW-1:0] data);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic set_limits(input logic [DeadbandW-1:0] db, input logic [TimeoutW-1:0] to);
    cfg_write(CfgDeadband, CfgDataW'(db));
    cfg_write(CfgTimeout, to);
    cfg_valid_i <= 1'b0;
    cur_db = 32'(db);
    cur_to = 32'(to);
    n_settings++;
  endtask

  task automatic send_random();
    int unsigned r;
    logic [1:0]  act;
    vel_vec_t    v;
    r = $urandom_range(0, 99);
    if (r < 30) act = ActManual;
    else if (r < 50) act = ActAuto;
    else if (r < 95) act = ActTick;
    else act = ActUnused;
    // Advance time mostly in small steps; sometimes land a tick right on the
    // timeout edge, sometimes jump anywhere so the clock wraps.
    r = $urandom_range(0, 99);
    if (act == ActTick && r < 15) now_ms = last_manual_ms + TimeW'(cur_to) + $urandom_range(0, 1);
    else if (r < 50) now_ms += $urandom_range(0, 3);
    else if (r < 85) now_ms += $urandom_range(0, cur_to / 8 + 1);
    else if (r < 97) now_ms += $urandom_range(0, cur_to + 2);
    else now_ms = $urandom();
    for (int i = 0; i < NumAxes; i++) v[i] = vel_t'($urandom());
    if (act == ActManual) begin
      v[AxisLinX] = pick_axis();
      v[AxisLinY] = pick_axis();
      v[AxisAngZ] = pick_axis();
      last_manual_ms = now_ms;
    end
    send_item(act, now_ms, v);
  endtask

  // Receiver: random stalls, a single long hold-off on request, none while calm.
  initial begin
    m_axis_tready = 1'b0;
    rx_stall      = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req      = 1'b0;
        rx_stall      = HoldOffCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rx_stall      = pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no channel has moved a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [DeadbandW-1:0] db;
    logic [TimeoutW-1:0]  to;

    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ActManual;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgDeadband;
    cfg_data_i     = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    idle_cycles    = 0;
    cur_db         = DeadbandReset;
    cur_to         = TimeoutReset;
    now_ms         = '0;
    last_manual_ms = '0;
    n_items        = 0;
    n_ticks        = 0;
    n_cmds         = 0;
    n_ignored      = 0;
    n_settings     = 0;
    rst_ni         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits. Nothing seen yet: ticks stay quiet, the unused code is dropped.
    send_item(ActTick, 32'd0, '0);
    send_item(ActUnused, '1, '1);
    // Manual exactly at the deadband is stored but is no activity.
    send_item(ActManual, 32'd10, mk_vel(16'sd205, -16'sd205, 0, 0, 0, 16'sd205));
    send_item(ActTick, 32'd11, '0);
    // Most negative lin_y is activity; elapsed equal to the timeout keeps manual.
    send_item(ActManual, 32'd100, mk_vel(16'sd1, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                         -16'sd1));
    send_item(ActTick, 32'd600, '0);
    // One past the timeout with no autonomous command: falls to none, zeros published.
    send_item(ActTick, 32'd601, '0);
    send_item(ActTick, 32'd602, '0);
    send_item(ActAuto, 32'hFFFF_FFFF, mk_vel(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                             16'sh7fff, 16'sh8000));
    send_item(ActTick, 32'd700, '0);
    send_item(ActTick, 32'd701, '0);
    // Activity just before the time wraps, tick after it.
    send_item(ActManual, 32'hFFFF_FF00, mk_vel(0, 0, 0, 0, 0, -16'sd206));
    send_item(ActTick, 32'h0000_0010, '0);
    // Large off-axis parts alone are no activity, yet they still pass through.
    send_item(ActManual, 32'h0000_0020, mk_vel(-16'sd205, 16'sd205, 16'sh8000, 16'sh7fff,
                                               16'sh8000, 0));
    send_item(ActTick, 32'h0000_00F4, '0);
    send_item(ActTick, 32'h0000_00F5, '0);
    // Activity and tick at the top of the time range.
    send_item(ActManual, 32'hFFFF_FFFF, mk_vel(16'sd206, 0, 0, 0, 0, 0));
    send_item(ActTick, 32'hFFFF_FFFF, '0);

    // Zero deadband and zero timeout: any nonzero lin_x, lin_y or ang_z counts, manual holds only within the same ms.
    wait_idle();
    set_limits('0, '0);
    send_item(ActManual, 32'd5000, mk_vel(0, 0, 0, 0, 0, 0));
    send_item(ActTick, 32'd5000, '0);
    send_item(ActManual, 32'd6000, mk_vel(0, 0, 0, 0, 0, 16'sd1));
    send_item(ActTick, 32'd6000, '0);
    send_item(ActTick, 32'd6001, '0);

    // Largest limits: only the most negative value is activity.
    wait_idle();
    set_limits('1, '1);
    send_item(ActManual, 32'd7000, mk_vel(16'sh7fff, 16'sh7fff, 0, 0, 0, 16'sh7fff));
    send_item(ActTick, 32'd7000, '0);
    send_item(ActManual, 32'd8000, mk_vel(16'sh8000, 0, 0, 0, 0, 0));
    send_item(ActTick, 32'd8000 + 32'd65535, '0);
    send_item(ActTick, 32'd8000 + 32'd65536, '0);

    // Random phases, each under its own limits.
    for (int p = 0; p < RandomPhases; p++) begin
      wait_idle();
      case (p)
        0: begin
          db = DeadbandW'($urandom_range(0, 600));
          to = TimeoutW'($urandom_range(0, 40));
        end
        1: begin db = '0;                         to = '0;                       end
        2: begin db = DeadbandReset;              to = TimeoutReset;             end
        3: begin
          db = DeadbandW'($urandom_range(0, 2000));
          to = TimeoutW'($urandom_range(0, 2000));
        end
        4: begin db = '1;                         to = '1;                       end
        default: begin
          db = DeadbandW'($urandom_range(0, 32767));
          to = TimeoutW'($urandom_range(0, 65535));
        end
      endcase
      set_limits(db, to);
      calm = (p == 3);
      for (int k = 0; k < PhaseItems; k++) begin
        // Back-to-back offers while the receiver holds off: the queue fills
        // and the input has to stall.
        if (p == 2 && k == 40) begin
          calm     = 1'b1;
          hold_req = 1'b1;
        end
        if (p == 2 && k == 100) calm = 1'b0;
        send_random();
      end
      calm = 1'b0;
    end

    wait_idle();
    $display("Covered %0d items (%0d ticks, %0d cmds, %0d unused) under %0d settings.",
             n_items, n_ticks, n_cmds, n_ignored, n_settings + 1);
    $display("Checked %0d published commands, %0d mismatches, %0d never arrived.",
             checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
